FILE: rtl/vector_project_to_sphere_unit_macros.svh
// Assertion macros shared by the sphere projection RTL.
`ifndef VECTOR_PROJECT_TO_SPHERE_UNIT_MACROS_SVH
`define VECTOR_PROJECT_TO_SPHERE_UNIT_MACROS_SVH

// Implication checked on every edge outside reset.
`define VPTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpts: check failed");

// Condition that must hold on the edge after a reset cycle.
`define VPTS_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("vpts: state after reset is wrong");

`endif

FILE: rtl/vpts_pkg.sv
// Shared types and constants of the sphere projection unit.
`timescale 1ns / 1ps
`default_nettype none

package vpts_pkg;

  localparam int IN_W       = 18;
  localparam int OUT_W      = 17;
  localparam int RAD_W      = 12;
  localparam int Q_W        = 17;
  localparam int SUM_W      = 36;
  localparam int M_W        = 56;
  localparam int MAG_PROD_W = RAD_W + IN_W;
  localparam int NUM_LANES  = 3;

  // Stage map: four preparation stages, one root stage per quotient bit,
  // then the output register.
  localparam int FIRST_ROOT = 4;
  localparam int LAST_ROOT  = FIRST_ROOT + Q_W - 1;
  localparam int NUM_STAGES = LAST_ROOT + 2;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 12'd256;
  localparam logic [Q_W-1:0]   POS_LIMIT    = 17'd65535;
  localparam logic [Q_W-1:0]   NEG_LIMIT    = 17'd65536;

  typedef enum logic [0:0] {
    REG_RADIUS = 1'b0
  } reg_index_t;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [M_W-1:0]   slope_t;
  typedef logic [Q_W-1:0]   quot_t;

endpackage

`default_nettype wire

FILE: rtl/vpts_if.sv
// Point and projection stream interfaces of the sphere projection unit.
`timescale 1ns / 1ps
`default_nettype none

interface vpts_point_if;
  import vpts_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] coord_x;
  logic signed [IN_W-1:0] coord_y;
  logic signed [IN_W-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface vpts_proj_if;
  import vpts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] proj_x;
  logic signed [OUT_W-1:0] proj_y;
  logic signed [OUT_W-1:0] proj_z;
  logic                    below_plane;
  logic                    zero_length;

  modport source (output valid, proj_x, proj_y, proj_z, below_plane, zero_length,
                  input ready);
  modport sink (input valid, proj_x, proj_y, proj_z, below_plane, zero_length,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/vpts_root_step.sv
// One registered stage of the root quotient search: decides one quotient bit.
`timescale 1ns / 1ps
`default_nettype none

module vpts_root_step #(
  parameter int BIT = 16,
  parameter int D_W = 76
) (
  input  logic              clk,
  input  logic              en,
  input  vpts_pkg::sum_t    sum,
  input  logic [D_W-1:0]    d_in,
  input  vpts_pkg::slope_t  m_in,
  input  vpts_pkg::quot_t   q_in,
  output logic [D_W-1:0]    d_out,
  output vpts_pkg::slope_t  m_out,
  output vpts_pkg::quot_t   q_out
);
  import vpts_pkg::*;

  logic [D_W-1:0] m_ext;
  logic [D_W-1:0] sum_ext;
  logic [D_W-1:0] trial;
  logic           take;

  // d holds the slack (2*num)^2 - (2q-1)^2*sum and m holds (2q-1)*sum.
  // Setting bit BIT grows the square term by 4*2^BIT*m + 4*4^BIT*sum.
  assign m_ext   = {{(D_W-M_W){m_in[M_W-1]}}, m_in};
  assign sum_ext = {{(D_W-SUM_W){1'b0}}, sum};
  assign trial   = d_in - (m_ext << (BIT + 2)) - (sum_ext << (2 * BIT + 2));
  assign take    = !trial[D_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= take ? trial : d_in;
      m_out <= take ? (m_in + (slope_t'(sum) << (BIT + 1))) : m_in;
      q_out <= take ? (q_in | (quot_t'(1) << BIT)) : q_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vector_project_to_sphere_unit.sv
// Top level of the sphere projection unit: pipeline, register port and checks.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_project_to_sphere_unit_macros.svh"

// Pushes each 3D point onto a sphere of programmable radius. A point beat carries
// signed coordinates (any number of fraction bits, the scale cancels); the result
// beat carries radius * c / |v| for each coordinate with OUTPUT_FRAC_BITS fraction
// bits, rounded to nearest with halves away from zero and saturated to 17 bits,
// plus a flag for a negative z and a flag for the all-zero vector, whose
// coordinates come out as zero. The unit takes one point per clock unless a
// full pipeline stalls behind the result side, and each point passes through four
// preparation stages (magnitudes and squares, the length sum and partial products
// of the scaled coordinate, the squared numerator, the starting slack), seventeen
// root-search stages that each settle one quotient bit exactly with shifts, adds
// and a sign test, and the output register. Valid bits travel with the data and a
// stage takes a new beat whenever it is empty or its occupant moves on, so a stall
// on the result side only closes the point side once every stage is full. The
// radius register sits at byte address 0 of the APB port, resets to 256 and must
// be written only while no point is in flight.
module vector_project_to_sphere_unit #(
  parameter int OUTPUT_FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  vpts_point_if.sink  points,
  vpts_proj_if.source projs,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vpts_pkg::*;

  localparam int NS     = NUM_STAGES;
  localparam int NUM_W  = MAG_PROD_W + OUTPUT_FRAC_BITS;
  localparam int NUM_LO = (NUM_W + 1) / 2;
  localparam int NUM_HI = NUM_W - NUM_LO;
  localparam int HH_W   = 2 * NUM_HI;
  localparam int HL_W   = NUM_HI + NUM_LO;
  localparam int LL_W   = 2 * NUM_LO;
  localparam int R_W    = 2 * NUM_W + 2;
  localparam int D_W    = ((R_W > 74) ? R_W : 74) + 2;

  // ---------------------------------------------------------------------------
  // Register port. Only the radius exists; other addresses read zero and ignore
  // writes.
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0] radius;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_RADIUS);
  assign prdata  = reg_hit ? {{(32-RAD_W){1'b0}}, radius} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      radius <= pwdata[RAD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A stage may load when it is empty or when some later stage is
  // empty or the result beat is being taken, so bubbles are squeezed out.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS:0]   vin;
  logic [NS-1:0] rdy;

  assign vin = {v, points.valid};

  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = projs.ready || !(&v[NS-1:i]);
  end

  assign points.ready = rdy[0];
  assign projs.valid  = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers. Lane 0 is x, lane 1 is y, lane 2 is z.
  // ---------------------------------------------------------------------------
  logic [IN_W-1:0]      coord [NUM_LANES];
  logic [IN_W-1:0]      mag   [NUM_LANES];

  logic [NUM_W-1:0]     s0_num [NUM_LANES];
  sum_t                 s0_sq  [NUM_LANES];
  logic [HH_W-1:0]      s1_hh  [NUM_LANES];
  logic [HL_W-1:0]      s1_hl  [NUM_LANES];
  logic [LL_W-1:0]      s1_ll  [NUM_LANES];
  logic [R_W-1:0]       s2_r   [NUM_LANES];
  logic [D_W-1:0]       d_start [NUM_LANES];
  slope_t               m_start [NUM_LANES];

  logic [D_W-1:0]       d_p [NUM_LANES][FIRST_ROOT-1:LAST_ROOT];
  slope_t               m_p [NUM_LANES][FIRST_ROOT-1:LAST_ROOT];
  quot_t                q_p [NUM_LANES][FIRST_ROOT:LAST_ROOT];

  sum_t                 sum_p   [1:LAST_ROOT-1];
  logic [NUM_LANES-1:0] neg_p   [NS-1];
  logic                 below_p [NS-1];
  logic                 zero_p  [2:NS-2];

  quot_t                sat   [NUM_LANES];
  logic [OUT_W-1:0]     res   [NUM_LANES];
  logic [OUT_W-1:0]     out_proj [NUM_LANES];
  logic                 out_below;
  logic                 out_zero;

  assign coord[0] = points.coord_x;
  assign coord[1] = points.coord_y;
  assign coord[2] = points.coord_z;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag[l] = coord[l][IN_W-1] ? (~coord[l] + 1'b1) : coord[l];
    end
  end

  // Stage 0: scaled magnitude radius*|c|*2^F and the squares of the coordinates.
  // Stage 1: length sum and the three partial products of the scaled magnitude.
  // Stage 2: squared doubled numerator (2*num)^2 and the zero-vector flag.
  // Stage 3: starting slack (2*num)^2 - sum and slope -sum for an empty quotient.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s0_num[l] <= NUM_W'(MAG_PROD_W'(radius) * MAG_PROD_W'(mag[l])) << OUTPUT_FRAC_BITS;
        s0_sq[l]  <= SUM_W'(mag[l]) * SUM_W'(mag[l]);
        neg_p[0][l] <= coord[l][IN_W-1];
      end
      below_p[0] <= points.coord_z[IN_W-1];
    end
    if (rdy[1]) begin
      sum_p[1] <= s0_sq[0] + s0_sq[1] + s0_sq[2];
      for (int l = 0; l < NUM_LANES; l++) begin
        s1_hh[l] <= HH_W'(s0_num[l][NUM_W-1:NUM_LO]) * HH_W'(s0_num[l][NUM_W-1:NUM_LO]);
        s1_hl[l] <= HL_W'(s0_num[l][NUM_W-1:NUM_LO]) * HL_W'(s0_num[l][NUM_LO-1:0]);
        s1_ll[l] <= LL_W'(s0_num[l][NUM_LO-1:0]) * LL_W'(s0_num[l][NUM_LO-1:0]);
      end
    end
    if (rdy[2]) begin
      zero_p[2] <= (sum_p[1] == '0);
      for (int l = 0; l < NUM_LANES; l++) begin
        s2_r[l] <= (R_W'(s1_hh[l]) << (2 * NUM_LO + 2))
                 + (R_W'(s1_hl[l]) << (NUM_LO + 3))
                 + (R_W'(s1_ll[l]) << 2);
      end
    end
    if (rdy[3]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        d_start[l] <= D_W'(s2_r[l]) - D_W'(sum_p[2]);
        m_start[l] <= slope_t'(0) - slope_t'(sum_p[2]);
      end
    end
    // Side information that rides along with each point.
    for (int i = 1; i < NS - 1; i++) begin
      if (rdy[i]) begin
        neg_p[i]   <= neg_p[i-1];
        below_p[i] <= below_p[i-1];
      end
    end
    for (int i = 3; i < NS - 1; i++) begin
      if (rdy[i]) begin
        zero_p[i] <= zero_p[i-1];
      end
    end
    for (int i = 2; i < LAST_ROOT; i++) begin
      if (rdy[i]) begin
        sum_p[i] <= sum_p[i-1];
      end
    end
  end

  // Root search: the quotient is the largest q below 2^17 with
  // (2q-1)^2 * sum <= (2*num)^2, which is num/sqrt(sum) rounded to nearest.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    assign d_p[l][FIRST_ROOT-1] = d_start[l];
    assign m_p[l][FIRST_ROOT-1] = m_start[l];
    for (genvar s = FIRST_ROOT; s <= LAST_ROOT; s++) begin : g_root
      quot_t q_prev;
      if (s == FIRST_ROOT) begin : g_first
        assign q_prev = '0;
      end else begin : g_next
        assign q_prev = q_p[l][s-1];
      end
      vpts_root_step #(
        .BIT (LAST_ROOT - s),
        .D_W (D_W)
      ) u_step (
        .clk   (clk),
        .en    (rdy[s]),
        .sum   (sum_p[s-1]),
        .d_in  (d_p[l][s-1]),
        .m_in  (m_p[l][s-1]),
        .q_in  (q_prev),
        .d_out (d_p[l][s]),
        .m_out (m_p[l][s]),
        .q_out (q_p[l][s])
      );
    end
  end

  // Output stage: clamp, apply the sign, force zero for a zero-length vector.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (neg_p[NS-2][l]) begin
        sat[l] = (q_p[l][LAST_ROOT] > NEG_LIMIT) ? NEG_LIMIT : q_p[l][LAST_ROOT];
        res[l] = ~sat[l] + 1'b1;
      end else begin
        sat[l] = (q_p[l][LAST_ROOT] > POS_LIMIT) ? POS_LIMIT : q_p[l][LAST_ROOT];
        res[l] = sat[l];
      end
      if (zero_p[NS-2]) begin
        res[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        out_proj[l] <= res[l];
      end
      out_below <= below_p[NS-2];
      out_zero  <= zero_p[NS-2];
    end
  end

  assign projs.proj_x      = out_proj[0];
  assign projs.proj_y      = out_proj[1];
  assign projs.proj_z      = out_proj[2];
  assign projs.below_plane = out_below;
  assign projs.zero_length = out_zero;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // After the last root stage the slack is never negative once any bit was set,
  // and the slope (2q-1)*sum is positive exactly when the quotient is nonzero.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
    `VPTS_ASSERT_IMP(a_slack_nonneg, clk, rst,
      v[LAST_ROOT] && (q_p[l][LAST_ROOT] != '0), !d_p[l][LAST_ROOT][D_W-1])
    `VPTS_ASSERT_IMP(a_slope_sign, clk, rst,
      v[LAST_ROOT] && !zero_p[LAST_ROOT],
      (q_p[l][LAST_ROOT] != '0) == !m_p[l][LAST_ROOT][M_W-1])
  end

  // The point side closes only while every stage is full and the result stalls.
  `VPTS_ASSERT_IMP(a_ready_only_full, clk, rst, !points.ready,
    projs.valid && !projs.ready)

  // A zero-length beat carries an all-zero point on or above the plane.
  `VPTS_ASSERT_IMP(a_zero_beat, clk, rst, projs.valid && projs.zero_length,
    (projs.proj_x == '0) && (projs.proj_y == '0) && (projs.proj_z == '0) &&
    !projs.below_plane)

  // Reset empties the pipeline and opens the point side.
  `VPTS_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !projs.valid && points.ready)

endmodule

`default_nettype wire

FILE: tb/sv/sphere_projection_checker.sv
// Checker that predicts and compares every projection beat of the sphere projection unit.
`timescale 1ns / 1ps

module sphere_projection_checker #(
  parameter int FRAC_OUT = 4
) (
  input  logic        clk,
  input  logic        rst,
  vpts_point_if       points,
  vpts_proj_if        projs,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import vpts_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    below_plane;
    logic                    zero_length;
  } projection_t;

  projection_t       awaited_projs[$];
  logic [RAD_W-1:0]  radius_now;

  initial begin
    errors  = 0;
    pending = 0;
    radius_now = RADIUS_RESET;
  end

  task automatic report_failure(input string what);
    if (errors < 200) begin
      $display("%0t: %s", $time, what);
    end
    errors++;
  endtask

  function automatic logic [IN_W-1:0] magnitude(input logic signed [IN_W-1:0] c);
    return c[IN_W-1] ? (~c + 1'b1) : c;
  endfunction

  // Rounded radius * |c| * 2^FRAC_OUT / sqrt(sum), found bit by bit: a trial
  // quotient t stays when (2t - 1)^2 * sum <= (2 * num)^2, which is exactly the
  // test for num / sqrt(sum) >= t - 1/2. The sign of c is applied afterward.
  function automatic logic signed [OUT_W-1:0] scale_coord(
    input logic signed [IN_W-1:0] c,
    input logic [SUM_W-1:0]       sum,
    input logic [RAD_W-1:0]       radius
  );
    logic [63:0]    num;
    logic [127:0]   target;
    logic [127:0]   trial;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] t;
    logic [Q_W:0]   k;
    num    = (64'(radius) * 64'(magnitude(c))) << FRAC_OUT;
    target = 128'(num << 1) * 128'(num << 1);
    q      = '0;
    for (int b = Q_W - 1; b >= 0; b--) begin
      t     = q | (Q_W'(1) << b);
      k     = {t, 1'b0} - 1'b1;
      trial = 128'(k) * 128'(k) * 128'(sum);
      if (trial <= target) q = t;
    end
    if (c < 0) begin
      if (q > NEG_LIMIT) q = NEG_LIMIT;
      return OUT_W'(-q);
    end
    if (q > POS_LIMIT) q = POS_LIMIT;
    return OUT_W'(q);
  endfunction

  function automatic projection_t project_point(
    input logic signed [IN_W-1:0] x,
    input logic signed [IN_W-1:0] y,
    input logic signed [IN_W-1:0] z,
    input logic [RAD_W-1:0]       radius
  );
    projection_t      p;
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(magnitude(x)) * SUM_W'(magnitude(x))
        + SUM_W'(magnitude(y)) * SUM_W'(magnitude(y))
        + SUM_W'(magnitude(z)) * SUM_W'(magnitude(z));
    p.below_plane = (z < 0);
    if (sum == '0) begin
      p.x = '0;
      p.y = '0;
      p.z = '0;
      p.zero_length = 1'b1;
    end else begin
      p.x = scale_coord(x, sum, radius);
      p.y = scale_coord(y, sum, radius);
      p.z = scale_coord(z, sum, radius);
      p.zero_length = 1'b0;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    projection_t want;
    projection_t got;
    if (rst) begin
      radius_now = RADIUS_RESET;
      awaited_projs.delete();
    end else begin
      if (psel && penable && pready && reg_index_t'(paddr[2]) == REG_RADIUS) begin
        if (pwrite) begin
          radius_now = pwdata[RAD_W-1:0];
        end else if (prdata !== 32'(radius_now)) begin
          report_failure($sformatf("radius read back as %0d, expected %0d",
                                   prdata, radius_now));
        end
      end
      if (points.valid && points.ready) begin
        awaited_projs = {awaited_projs,
                         project_point(points.coord_x, points.coord_y,
                                       points.coord_z, radius_now)};
      end
      if (projs.valid && projs.ready) begin
        got = '{projs.proj_x, projs.proj_y, projs.proj_z,
                projs.below_plane, projs.zero_length};
        if (awaited_projs.size() == 0) begin
          report_failure("projection beat arrived with none outstanding");
        end else begin
          want = awaited_projs.pop_front();
          if (got.x !== want.x)
            report_failure($sformatf("proj_x is %0d, expected %0d", got.x, want.x));
          if (got.y !== want.y)
            report_failure($sformatf("proj_y is %0d, expected %0d", got.y, want.y));
          if (got.z !== want.z)
            report_failure($sformatf("proj_z is %0d, expected %0d", got.z, want.z));
          if (got.below_plane !== want.below_plane)
            report_failure($sformatf("below_plane is %b, expected %b",
                                     got.below_plane, want.below_plane));
          if (got.zero_length !== want.zero_length)
            report_failure($sformatf("zero_length is %b, expected %b",
                                     got.zero_length, want.zero_length));
        end
      end
    end
    pending = awaited_projs.size();
  end

endmodule

FILE: tb/sv/tb_vector_project_to_sphere_unit.sv
// Top of the sphere projection testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_vector_project_to_sphere_unit;
  import vpts_pkg::*;

  // Settling wait that lets every pipeline register of the unit empty.
  localparam int LATENCY     = 22;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_BEATS = 135;
  localparam int SQUEEZE_CYCLES = 300;

  // Byte address 4 decodes to register index 1, which does not exist.
  localparam logic [2:0] UNMAPPED_ADDR = 3'd4;
  localparam logic [2:0] RADIUS_ADDR   = {REG_RADIUS, 2'b00};

  typedef enum int {SPAN_FULL, SPAN_SMALL, SPAN_EDGE, SPAN_ZERO} coord_span_e;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int proj_errors;
  int proj_pending;
  int cycle_count;

  // Idle rates in percent for the two sides, and the request for a long
  // receiver hold-off that fills the pipeline.
  int sender_idle_pct;
  int stall_pct;
  bit hold_request;

  vpts_point_if points();
  vpts_proj_if  projs();

  vector_project_to_sphere_unit dut (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .projs   (projs),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sphere_projection_checker proj_check (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .projs   (projs),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .errors  (proj_errors),
    .pending (proj_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side. Normally ready follows the stall rate of the phase; when a
  // hold-off is requested, ready stays low for a long, counted stretch while
  // the sender keeps offering points, so every stage fills and the point side
  // has to close.
  initial begin
    int hold_left;
    hold_left = 0;
    projs.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        projs.ready <= 1'b0;
        hold_left--;
      end else begin
        projs.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // APB write: setup, then access until pready.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads are checked by the checker against its own copy of the radius.
  task automatic apb_read(input logic [2:0] addr);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The radius sits in the low 12 bits; the upper bits of the write data get
  // random junk so the masking of the register is exercised too.
  task automatic program_radius(input logic [RAD_W-1:0] radius);
    apb_write(RADIUS_ADDR, {20'($urandom()), radius});
    apb_read(RADIUS_ADDR);
  endtask

  // One point beat. At each falling edge the sender either idles or presents
  // the point; valid is driven once per step, so back-to-back beats keep it
  // high without a glitch. The beat is taken at the rising edge with ready.
  task automatic send_point(input logic signed [IN_W-1:0] x,
                            input logic signed [IN_W-1:0] y,
                            input logic signed [IN_W-1:0] z);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      points.valid <= 1'b0;
      @(negedge clk);
    end
    points.valid   <= 1'b1;
    points.coord_x <= x;
    points.coord_y <= y;
    points.coord_z <= z;
    do @(posedge clk); while (!points.ready);
  endtask

  task automatic stop_points();
    @(negedge clk);
    points.valid <= 1'b0;
  endtask

  // The register may only change with nothing in flight: wait for the last
  // projection beat, then let the LATENCY settling wait go by.
  task automatic settle();
    while (proj_pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] pick_coord(input coord_span_e span);
    case (span)
      SPAN_FULL:  return IN_W'($urandom());
      SPAN_SMALL: return IN_W'($urandom_range(0, 255)) - IN_W'(128);
      SPAN_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return {1'b0, {(IN_W-1){1'b1}}};
          1:       return {1'b1, {(IN_W-1){1'b0}}};
          2:       return '1;
          3:       return IN_W'(1);
          default: return '0;
        endcase
      end
      default:    return '0;
    endcase
  endfunction

  // Many points span the whole range so every coordinate bit toggles; the
  // rest are short vectors, one dominant axis, edge values and mixes that
  // now and then come out as the all-zero vector.
  task automatic send_random_point();
    coord_span_e sx;
    coord_span_e sy;
    coord_span_e sz;
    int          axis;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        sx = SPAN_FULL;
        sy = SPAN_FULL;
        sz = SPAN_FULL;
      end
      4, 5: begin
        sx = SPAN_SMALL;
        sy = SPAN_SMALL;
        sz = SPAN_SMALL;
      end
      6: begin
        axis = $urandom_range(0, 2);
        sx = (axis == 0) ? SPAN_FULL : SPAN_SMALL;
        sy = (axis == 1) ? SPAN_FULL : SPAN_SMALL;
        sz = (axis == 2) ? SPAN_FULL : SPAN_SMALL;
      end
      7: begin
        sx = SPAN_EDGE;
        sy = SPAN_EDGE;
        sz = SPAN_EDGE;
      end
      default: begin
        sx = coord_span_e'($urandom_range(0, 3));
        sy = coord_span_e'($urandom_range(0, 3));
        sz = coord_span_e'($urandom_range(0, 3));
      end
    endcase
    send_point(pick_coord(sx), pick_coord(sy), pick_coord(sz));
  endtask

  task automatic run_phase(input logic [RAD_W-1:0] radius, input int idle_pct,
                           input int stall, input bit squeeze);
    settle();
    program_radius(radius);
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
    if (squeeze) hold_request = 1'b1;
    repeat (PHASE_BEATS) send_random_point();
    stop_points();
  endtask

  // Directed points at the reset radius: the zero vector, each axis at both
  // ends of its range, unit steps, all-ones, exact Pythagorean lengths, a
  // component too small to survive rounding and a point just below the plane.
  int directed_pts[16][3] = '{
    '{0, 0, 0},
    '{131071, 0, 0},
    '{-131072, 0, 0},
    '{0, 131071, 0},
    '{0, -131072, 0},
    '{0, 0, 131071},
    '{0, 0, -131072},
    '{1, 0, 0},
    '{-1, -1, -1},
    '{131071, 131071, 131071},
    '{-131072, -131072, -131072},
    '{3, 4, 0},
    '{2, -3, 6},
    '{-131072, 131071, -1},
    '{1, 131071, 0},
    '{0, 0, -1}
  };

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    points.valid    = 1'b0;
    points.coord_x  = '0;
    points.coord_y  = '0;
    points.coord_z  = '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_request    = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // The radius must read back as its reset value before any write.
    apb_read(RADIUS_ADDR);
    foreach (directed_pts[i]) begin
      send_point(IN_W'(directed_pts[i][0]), IN_W'(directed_pts[i][1]),
                 IN_W'(directed_pts[i][2]));
    end
    stop_points();

    // A write to the unmapped index must leave the radius alone.
    settle();
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    apb_read(RADIUS_ADDR);

    // Zero radius collapses every point to the origin.
    program_radius('0);
    send_point(IN_W'(5), IN_W'(-7), IN_W'(9));
    send_point('0, '0, '0);
    stop_points();

    // Largest radius with single-axis and diagonal points.
    settle();
    program_radius('1);
    send_point({1'b0, {(IN_W-1){1'b1}}}, '0, '0);
    send_point({1'b1, {(IN_W-1){1'b0}}}, '0, '0);
    send_point(IN_W'(1), IN_W'(1), IN_W'(1));
    stop_points();

    // Random phases walk through the idling mixes, with stretches of no
    // idling at all, and through the radius extremes and random radii. The
    // long hold-off lands in a phase where the sender never idles.
    run_phase('1, 0, 0, 1'b0);
    run_phase('0, 58, 0, 1'b0);
    run_phase(RAD_W'(1), 0, 58, 1'b0);
    run_phase(RAD_W'($urandom_range(0, 4095)), 21, 21, 1'b0);
    run_phase('1, 0, 0, 1'b1);
    run_phase(RAD_W'($urandom_range(0, 4095)), 58, 0, 1'b0);
    run_phase(RAD_W'($urandom_range(0, 4095)), 0, 58, 1'b0);
    run_phase(RADIUS_RESET, 21, 21, 1'b0);

    // Drain, then leave room for any stray beat to show up.
    while (proj_pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    if (proj_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vpts_pkg.sv
rtl/vpts_if.sv
rtl/vpts_root_step.sv
rtl/vector_project_to_sphere_unit.sv
tb/sv/sphere_projection_checker.sv
tb/sv/tb_vector_project_to_sphere_unit.sv
